[hdl/tiled_4bpp_icon_decoder_core_assert.svh]
// Assertion macros shared by the checker of the icon decoder core.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef TILED_4BPP_ICON_DECODER_CORE_ASSERT_SVH
`define TILED_4BPP_ICON_DECODER_CORE_ASSERT_SVH

// Implication in the same cycle, masked while reset is asserted.
`define T4ID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, masked while reset is asserted.
`define T4ID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that is also checked during reset.
`define T4ID_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/t4id_pkg.sv]
`timescale 1ns / 1ps

package t4id_pkg;

  // Operation codes of an input request.
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_TILE    = 1'b1;

  localparam int PAL_DEPTH   = 16;
  localparam int PAL_IDX_W   = 4;
  localparam int COLOR_W     = 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic                 operation;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [COLOR_W-1:0]   color;
    logic [7:0]           tile_byte;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [31:0] left_rgba;
    logic [31:0] right_rgba;
    logic        last_of_icon;
  } out_res_t;

  // One classified request waiting between the front and back ends.
  typedef struct packed {
    logic                 operation;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [COLOR_W-1:0]   color;
    logic [7:0]           tile_byte;
    logic [4:0]           pixel_x;
    logic [4:0]           pixel_y;
    logic                 last_of_icon;
  } q_entry_t;

  // Widens each 5-bit channel of a BGR555 color into RGBA8888, red on top.
  function automatic logic [31:0] expand_rgba(input logic [COLOR_W-1:0] c,
                                              input logic opaque);
    expand_rgba = {c[4:0], 3'b000, c[9:5], 3'b000, c[14:10], 3'b000,
                   (opaque ? ALPHA_OPAQUE : ALPHA_CLEAR)};
  endfunction

endpackage

[hdl/t4id_front.sv]
`timescale 1ns / 1ps

module t4id_front #(
  parameter int TILES_PER_SIDE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  t4id_pkg::in_req_t  in_req,
  input  logic               q_full,
  output logic               q_push,
  output t4id_pkg::q_entry_t q_push_entry
);
  import t4id_pkg::*;

  localparam int TW = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
  localparam logic [TW-1:0] TILE_MAX = TW'(TILES_PER_SIDE - 1);

  logic [1:0]    col_r, col_nxt;
  logic [2:0]    row_r, row_nxt;
  logic [TW-1:0] tx_r, tx_nxt;
  logic [TW-1:0] ty_r, ty_nxt;
  logic [TW+1:0] tx_ext, ty_ext;
  logic          accept, is_tile, row_end, tile_end, band_end, icon_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_tile  = (in_req.operation == OP_TILE);

  assign row_end  = (col_r == 2'd3);
  assign tile_end = row_end && (row_r == 3'd7);
  assign band_end = tile_end && (tx_r == TILE_MAX);
  assign icon_end = band_end && (ty_r == TILE_MAX);

  // Raster position: the column pair and tile column make x, the row and
  // tile row make y; only the low bits survive the 5-bit fields.
  assign tx_ext = {2'b00, tx_r};
  assign ty_ext = {2'b00, ty_r};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    tx_nxt  = tx_r;
    ty_nxt  = ty_r;
    if (accept && is_tile) begin
      col_nxt = col_r + 2'd1;
      if (row_end) begin
        row_nxt = row_r + 3'd1;
      end
      if (tile_end) begin
        tx_nxt = band_end ? '0 : tx_r + TW'(1);
      end
      if (band_end) begin
        ty_nxt = icon_end ? '0 : ty_r + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      tx_r  <= '0;
      ty_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
    end
  end

  always_comb begin
    q_push                     = accept;
    q_push_entry.operation     = in_req.operation;
    q_push_entry.palette_index = in_req.palette_index;
    q_push_entry.color         = in_req.color;
    q_push_entry.tile_byte     = in_req.tile_byte;
    q_push_entry.pixel_x       = {tx_ext[1:0], col_r, 1'b0};
    q_push_entry.pixel_y       = {ty_ext[1:0], row_r};
    q_push_entry.last_of_icon  = icon_end;
  end

endmodule

[hdl/t4id_queue.sv]
`timescale 1ns / 1ps

module t4id_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  t4id_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output t4id_pkg::q_entry_t head
);
  import t4id_pkg::*;

  q_entry_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hdl/t4id_back.sv]
`timescale 1ns / 1ps

module t4id_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  t4id_pkg::q_entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output t4id_pkg::out_res_t out_res
);
  import t4id_pkg::*;

  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

  logic               out_valid_r, out_valid_nxt;
  logic [4:0]         x_r, y_r;
  logic               last_r;
  logic [COLOR_W-1:0] lcol_r, rcol_r;
  logic               lop_r, rop_r;
  logic               out_free, pal_pop, tile_pop;

  // A palette write needs no result slot, so it leaves the queue at once;
  // a tile byte waits until the result register is empty or being taken.
  assign out_free = !out_valid_r || !out_stall;
  assign pal_pop  = q_valid && (q_head.operation == OP_PALETTE);
  assign tile_pop = q_valid && (q_head.operation == OP_TILE) && out_free;
  assign q_pop    = pal_pop || tile_pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tile_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_pop) begin
      pal_mem[q_head.palette_index] <= q_head.color;
    end
  end

  always_ff @(posedge clk) begin
    if (tile_pop) begin
      x_r    <= q_head.pixel_x;
      y_r    <= q_head.pixel_y;
      last_r <= q_head.last_of_icon;
      lcol_r <= pal_mem[q_head.tile_byte[3:0]];
      rcol_r <= pal_mem[q_head.tile_byte[7:4]];
      lop_r  <= (q_head.tile_byte[3:0] != '0);
      rop_r  <= (q_head.tile_byte[7:4] != '0);
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_res.pixel_x      = x_r;
    out_res.pixel_y      = y_r;
    out_res.left_rgba    = expand_rgba(lcol_r, lop_r);
    out_res.right_rgba   = expand_rgba(rcol_r, rop_r);
    out_res.last_of_icon = last_r;
  end

endmodule

[hdl/tiled_4bpp_icon_decoder_core.sv]
`timescale 1ns / 1ps
// A tile byte passes through the queue and a palette lookup into the result register.
// Throughput: one request per cycle, loads and bytes alike, if out_stall is low; a load gives no result.
// The figure is set by the single palette read stage, which looks up both pixels of a byte together.
// Reset (rst_n, synchronous, active low) clears the byte counters, the queue and the result valid.
// Palette contents are not cleared; an entry must be loaded before any tile byte refers to it.

module tiled_4bpp_icon_decoder_core #(
  parameter int TILES_PER_SIDE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  t4id_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output t4id_pkg::out_res_t out_res
);
  import t4id_pkg::*;

  // The front end counts tile bytes and tags each request with its raster
  // position, so the back end never needs the counters. Both request kinds
  // travel through the same queue, which keeps palette writes ordered with
  // the tile bytes around them: a byte ahead of a palette load still sees
  // the old color, and every byte behind it sees the new one.
  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_push_entry, q_head;

  t4id_front #(
    .TILES_PER_SIDE(TILES_PER_SIDE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_entry(q_push_entry)
  );

  // A two-entry queue lets the front keep accepting while the result
  // register is stalled, and lets palette loads drain while it waits.
  t4id_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  // The back end owns the palette store; it writes loads and looks up both
  // nibbles of a tile byte straight into the result register.
  t4id_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

endmodule

[hdl/t4id_checker.sv]
`timescale 1ns / 1ps
`include "tiled_4bpp_icon_decoder_core_assert.svh"

module t4id_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input t4id_pkg::out_res_t out_res
);
  import t4id_pkg::*;

  logic stall_seen;
  logic last_ok;
  logic alpha_ok;

  assign stall_seen = out_valid && out_stall;

  // The final byte of an icon is always the bottom-right byte of its tile.
  assign last_ok = !out_res.last_of_icon ||
                   ((out_res.pixel_x[2:0] == 3'd6) && (out_res.pixel_y[2:0] == 3'd7));

  assign alpha_ok = ((out_res.left_rgba[7:0] == ALPHA_OPAQUE) ||
                     (out_res.left_rgba[7:0] == ALPHA_CLEAR)) &&
                    ((out_res.right_rgba[7:0] == ALPHA_OPAQUE) ||
                     (out_res.right_rgba[7:0] == ALPHA_CLEAR));

  `T4ID_ASSERT_RESET(a_reset_clears_out, !rst_n, !out_valid, "result valid after reset")
  `T4ID_ASSERT_NEXT(a_stall_holds, stall_seen, out_valid && $stable(out_res), "held result moved")
  `T4ID_ASSERT_SAME(a_x_even, out_valid, !out_res.pixel_x[0], "odd left pixel column")
  `T4ID_ASSERT_SAME(a_last_corner, out_valid, last_ok, "last byte not at tile corner")
  `T4ID_ASSERT_SAME(a_alpha_codes, out_valid, alpha_ok, "bad alpha value")

endmodule

bind tiled_4bpp_icon_decoder_core t4id_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_res  (out_res)
);

[tb/tb_tiled_4bpp_icon_decoder_core.sv]
`timescale 1ns / 1ps

module tb_tiled_4bpp_icon_decoder_core;
  import t4id_pkg::*;

  // The icon geometry matches the block's default parameter.
  localparam int TILES_PER_SIDE = 4;
  localparam int BYTES_PER_TILE = 32;
  localparam int ICON_BYTES = TILES_PER_SIDE * TILES_PER_SIDE * BYTES_PER_TILE;

  // Random requests per idling phase. There are four phases, about 1500 requests in all.
  localparam int PHASE_REQS = 375;
  // The receiver holds off this long once, so that the block fills and stalls its input.
  localparam int LONG_HOLD_CYCLES = 300;
  // A result passes through the queue and the result register, so a short quiet period at the end is enough.
  localparam int DRAIN_CYCLES = 20;
  // The slowest correct run is roughly 1600 requests with their gaps and stalls,
  // plus the long hold. The limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 200;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  // Requests still to be offered, filled by the stimulus process below.
  in_req_t  pending_reqs[$];
  // Pixel pairs that the decoder should still produce, oldest first.
  out_res_t expected_pixels[$];

  // Shadow copy of the palette and of the byte counter of the decoder.
  logic [COLOR_W-1:0] pal_colors [PAL_DEPTH];
  int unsigned        byte_pos = 0;

  // Idling controls; the percentages change only between phases while the block is empty.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_cycles = 0;

  // Set at each rising edge when the request on the input was taken.
  bit req_taken = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  tiled_4bpp_icon_decoder_core #(
    .TILES_PER_SIDE(TILES_PER_SIDE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A palette index of zero is always transparent, whatever color its entry holds.
  // Each 5-bit channel lands in the top of its byte with the low three bits cleared.
  function automatic logic [31:0] to_rgba8888(input logic [PAL_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    c = pal_colors[idx];
    red = {c[4:0], 3'b000};
    green = {c[9:5], 3'b000};
    blue = {c[14:10], 3'b000};
    return {red, green, blue, (idx == '0) ? ALPHA_CLEAR : ALPHA_OPAQUE};
  endfunction

  // Applies one accepted request to the shadow state. A palette load only updates the
  // shadow palette and leaves the byte counter alone. A tile byte yields one pixel pair
  // whose position comes from the counter: the low two bits pick the column pair, the
  // next three the row within the tile, and the rest the tile in raster order of tiles.
  task automatic decode_request(input in_req_t r);
    out_res_t pix;
    int unsigned col;
    int unsigned row;
    int unsigned tile;
    int unsigned x;
    int unsigned y;
    if (r.operation == OP_PALETTE) begin
      pal_colors[r.palette_index] = r.color;
    end else begin
      col = byte_pos % 4;
      row = (byte_pos / 4) % 8;
      tile = byte_pos / BYTES_PER_TILE;
      x = col * 2 + 8 * (tile % TILES_PER_SIDE);
      y = row + 8 * (tile / TILES_PER_SIDE);
      pix.pixel_x = x[4:0];
      pix.pixel_y = y[4:0];
      pix.left_rgba = to_rgba8888(r.tile_byte[3:0]);
      pix.right_rgba = to_rgba8888(r.tile_byte[7:4]);
      pix.last_of_icon = (byte_pos == ICON_BYTES - 1);
      expected_pixels.push_back(pix);
      // The counter wraps after the last byte, and the next icon starts at the origin.
      byte_pos = (byte_pos == ICON_BYTES - 1) ? 0 : byte_pos + 1;
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    end
  endtask

  // Input acceptance and result checking both happen on the rising edge, where every
  // input was set at the falling edge before. A request is predicted as soon as it is taken,
  // which is always ahead of its result since the result register sits behind the queue.
  always @(posedge clk) begin
    out_res_t want;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken)
      decode_request(in_req);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
      end else begin
        want = expected_pixels.pop_front();
        report_field("pixel_x", 32'(want.pixel_x), 32'(out_res.pixel_x));
        report_field("pixel_y", 32'(want.pixel_y), 32'(out_res.pixel_y));
        report_field("left_rgba", want.left_rgba, out_res.left_rgba);
        report_field("right_rgba", want.right_rgba, out_res.right_rgba);
        report_field("last_of_icon", 32'(want.last_of_icon), 32'(out_res.last_of_icon));
      end
    end
  end

  // The driver moves to the next request only once the current one was taken, so a
  // stalled request keeps both its valid and its payload. Gaps are drawn per cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver either works through a long hold-off or stalls at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      out_stall <= 1'b1;
      recv_hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Fields that an operation does not use are filled with noise, since the block must
  // ignore them.
  function automatic in_req_t palette_load(input logic [PAL_IDX_W-1:0] idx,
                                           input logic [COLOR_W-1:0] c);
    in_req_t r;
    r.operation = OP_PALETTE;
    r.palette_index = idx;
    r.color = c;
    r.tile_byte = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic in_req_t tile_request(input logic [7:0] b);
    in_req_t r;
    r.operation = OP_TILE;
    r.palette_index = PAL_IDX_W'($urandom_range(PAL_DEPTH - 1));
    r.color = COLOR_W'($urandom_range(32767));
    r.tile_byte = b;
    return r;
  endfunction

  // Mostly tile bytes, with palette reloads sprinkled in the middle of icons. Extreme
  // colors and bytes that hit the transparent index show up more often than by chance.
  task automatic queue_random_reqs(input int count);
    int pick;
    logic [COLOR_W-1:0] c;
    logic [7:0] b;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        case ($urandom_range(4))
          0: c = '0;
          1: c = '1;
          default: c = COLOR_W'($urandom_range(32767));
        endcase
        pending_reqs.push_back(palette_load(PAL_IDX_W'($urandom_range(PAL_DEPTH - 1)), c));
      end else begin
        b = 8'($urandom_range(255));
        if (pick < 20)
          b[3:0] = 4'h0;
        else if (pick < 28)
          b[7:4] = 4'h0;
        pending_reqs.push_back(tile_request(b));
      end
    end
  endtask

  // Waits until every request went in and every result came out.
  task automatic wait_until_empty();
    while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The whole palette is loaded before the first tile byte, since the
    // entries are undefined until written. Index zero gets full white to show that it
    // stays transparent, and the single-channel colors check each channel's placement.
    for (k = 0; k < PAL_DEPTH; k++) begin
      case (k)
        0: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h7FFF));
        1: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h001F));
        2: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h03E0));
        3: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h7C00));
        4: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h0000));
        15: pending_reqs.push_back(palette_load(PAL_IDX_W'(k), 15'h7FFF));
        default: pending_reqs.push_back(palette_load(PAL_IDX_W'(k),
                                                     COLOR_W'($urandom_range(32767))));
      endcase
    end
    pending_reqs.push_back(tile_request(8'h00));
    pending_reqs.push_back(tile_request(8'hFF));
    pending_reqs.push_back(tile_request(8'h0F));
    pending_reqs.push_back(tile_request(8'hF0));
    pending_reqs.push_back(tile_request(8'h10));
    pending_reqs.push_back(tile_request(8'h21));
    pending_reqs.push_back(tile_request(8'h43));
    // A reload in the middle of an icon must apply to the very next byte and must not
    // move the byte counter.
    pending_reqs.push_back(palette_load(4'h1, 15'h5555));
    pending_reqs.push_back(tile_request(8'h11));
    wait_until_empty();

    // No idling on either side. Part way in, the receiver holds off for a long stretch
    // while the sender keeps offering, so the internal queue fills and the input stalls.
    set_idling(0, 0);
    queue_random_reqs(PHASE_REQS);
    repeat (40) @(posedge clk);
    recv_hold_cycles = LONG_HOLD_CYCLES;
    wait_until_empty();

    // The sender pauses here until every result is back, then idles heavily.
    set_idling(66, 0);
    queue_random_reqs(PHASE_REQS);
    wait_until_empty();

    set_idling(0, 66);
    queue_random_reqs(PHASE_REQS);
    wait_until_empty();

    set_idling(28, 28);
    queue_random_reqs(PHASE_REQS);
    wait_until_empty();

    // Any stray result during the quiet period is caught by the checker above.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      error_count++;
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
